FILE: sv/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    // Widths of the saturating length counter and of the stream offset counter.
    localparam int LEN_BITS    = 16;
    localparam int OFFSET_BITS = 32;

    // Depth of the queue between the classifier and the scanner.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Character codes that the scanner looks for.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_NUMBER  = 3'd1,
        KIND_STRING  = 3'd2,
        KIND_LINEC   = 3'd3,
        KIND_BLOCKC  = 3'd4,
        KIND_IDENT   = 3'd5,
        KIND_OPER    = 3'd6,
        KIND_NEWLINE = 3'd7
    } kind_t;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_STR   = 3'd2,
        MODE_SLASH = 3'd3,
        MODE_LINE  = 3'd4,
        MODE_BLOCK = 3'd5,
        MODE_IDENT = 3'd6
    } mode_t;

    // Character class flags worked out by the front end.
    typedef struct packed {
        logic is_digit;
        logic is_alpha;
        logic is_punct;
        logic is_blank;
    } char_class_t;

    // One classified input item as it travels through the queue.
    typedef struct packed {
        logic                   cmd;
        logic [7:0]             src_char;
        char_class_t            cls;
        logic [OFFSET_BITS-1:0] pos;
    } item_t;

    // One token result.
    typedef struct packed {
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    length;
        logic                   last;
    } tok_t;

endpackage

FILE: sv/sst_front.sv
`timescale 1ns / 1ps

module sst_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  logic               cmd,
    input  logic [7:0]         source_byte,
    output logic               push_valid,
    output sst_pkg::item_t     push_item,
    input  logic               queue_full
);

    logic [sst_pkg::OFFSET_BITS-1:0] offset_reg;
    logic [sst_pkg::OFFSET_BITS-1:0] offset_next;
    logic                            accept;

    // The queue being full is the only reason to hold off the source.
    assign src_stall  = queue_full;
    assign accept     = src_valid && !queue_full;
    assign push_valid = accept;

    // Classify the byte and tag it with its stream offset.
    always_comb
    begin
        push_item              = '0;
        push_item.cmd          = cmd;
        push_item.src_char     = source_byte;
        push_item.pos          = offset_reg;
        push_item.cls.is_digit = (source_byte >= 8'h30) && (source_byte <= 8'h39);
        push_item.cls.is_alpha = ((source_byte >= 8'h61) && (source_byte <= 8'h7A)) ||
                                 ((source_byte >= 8'h41) && (source_byte <= 8'h5A));
        push_item.cls.is_punct = ((source_byte >= 8'd33)  && (source_byte <= 8'd47)) ||
                                 ((source_byte >= 8'd58)  && (source_byte <= 8'd64)) ||
                                 ((source_byte >= 8'd91)  && (source_byte <= 8'd96)) ||
                                 ((source_byte >= 8'd123) && (source_byte <= 8'd126));
        push_item.cls.is_blank = (source_byte == sst_pkg::CH_SPACE) ||
                                 (source_byte == sst_pkg::CH_TAB) ||
                                 (source_byte == sst_pkg::CH_CR);
    end

    // The offset advances on every source byte; the end marker leaves it alone.
    always_comb
    begin
        offset_next = offset_reg;
        if (accept && !cmd)
        begin
            offset_next = offset_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

endmodule

FILE: sv/sst_queue.sv
`timescale 1ns / 1ps

module sst_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  sst_pkg::item_t  push_item,
    output logic            full,
    output logic            head_valid,
    output sst_pkg::item_t  head_item,
    input  logic            pop
)
;

    sst_pkg::item_t                  entry_reg [sst_pkg::QUEUE_DEPTH];
    logic [sst_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [sst_pkg::QPTR_BITS-1:0]   wr_ptr_next;
    logic [sst_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [sst_pkg::QPTR_BITS-1:0]   rd_ptr_next;
    logic [sst_pkg::QCNT_BITS-1:0]   count_reg;
    logic [sst_pkg::QCNT_BITS-1:0]   count_next;
    logic                            wr;
    logic                            rd;

    assign full       = (count_reg == sst_pkg::QCNT_BITS'(sst_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign wr         = push_valid && !full;
    assign rd         = pop && head_valid;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == sst_pkg::QPTR_BITS'(sst_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == sst_pkg::QPTR_BITS'(sst_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count never goes past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sst_pkg::QCNT_BITS'(sst_pkg::QUEUE_DEPTH))
        else $error("queue fill count exceeds its depth");

    // A lone write grows the queue by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a write");

    // A simultaneous read and write leaves the fill count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && rd) |=> (count_reg == $past(count_reg)))
        else $error("queue count changed on a read with a write");

endmodule

FILE: sv/sst_back.sv
`timescale 1ns / 1ps

module sst_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  sst_pkg::item_t  head_item,
    output logic            pop,
    output logic            tok_valid,
    input  logic            tok_stall,
    output sst_pkg::tok_t   tok_out
);

    // Scanner state.
    sst_pkg::mode_t                  mode_reg;
    sst_pkg::mode_t                  mode_next;
    logic                            dot_reg;
    logic                            dot_next;
    logic [1:0]                      exp_reg;
    logic [1:0]                      exp_next;
    logic                            prev_e_reg;
    logic                            prev_e_next;
    logic                            prev_star_reg;
    logic                            prev_star_next;
    logic [sst_pkg::OFFSET_BITS-1:0] start_reg;
    logic [sst_pkg::OFFSET_BITS-1:0] start_next;
    logic [sst_pkg::LEN_BITS-1:0]    len_reg;
    logic [sst_pkg::LEN_BITS-1:0]    len_next;

    // Two-entry result buffer; slot 0 drives the result channel.
    sst_pkg::tok_t                   slot_reg [2];
    sst_pkg::tok_t                   slot_next [2];
    logic [1:0]                      cnt_reg;
    logic [1:0]                      cnt_next;

    // Per-item decode.
    logic [7:0]                      ch;
    logic [sst_pkg::LEN_BITS-1:0]    len_bump;
    logic                            take;
    logic                            out_pop;
    logic                            fin_v;
    sst_pkg::kind_t                  fin_kind;
    logic [sst_pkg::LEN_BITS-1:0]    fin_len;
    logic                            scan;
    logic                            idl_v;
    sst_pkg::kind_t                  idl_kind;
    logic                            enter_block;
    sst_pkg::tok_t                   fin_tok;
    sst_pkg::tok_t                   idl_tok;
    sst_pkg::tok_t                   res_a;
    logic [1:0]                      res_n;

    assign ch        = head_item.src_char;
    assign len_bump  = (&len_reg) ? len_reg : len_reg + 1'b1;
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok_out   = slot_reg[0];
    assign out_pop   = tok_valid && !tok_stall;

    // An item is taken only when the buffer will be empty after this cycle's transfer.
    assign take = head_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_pop));
    assign pop  = take;

    // Scanner next state and the token that the current one may finish.
    always_comb
    begin
        mode_next      = mode_reg;
        dot_next       = dot_reg;
        exp_next       = exp_reg;
        prev_e_next    = prev_e_reg;
        prev_star_next = prev_star_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        fin_v          = 1'b0;
        fin_kind       = sst_pkg::KIND_INVALID;
        fin_len        = len_reg;
        scan           = 1'b0;
        idl_v          = 1'b0;
        idl_kind       = sst_pkg::KIND_INVALID;
        enter_block    = 1'b0;

        if (head_item.cmd)
        begin
            // End of source: report whatever is pending and go idle.
            unique case (mode_reg)
                sst_pkg::MODE_NUM:
                begin
                    fin_v    = 1'b1;
                    fin_kind = sst_pkg::KIND_NUMBER;
                end
                sst_pkg::MODE_IDENT:
                begin
                    fin_v    = 1'b1;
                    fin_kind = sst_pkg::KIND_IDENT;
                end
                sst_pkg::MODE_SLASH:
                begin
                    fin_v    = 1'b1;
                    fin_kind = sst_pkg::KIND_OPER;
                end
                sst_pkg::MODE_STR, sst_pkg::MODE_LINE, sst_pkg::MODE_BLOCK:
                begin
                    fin_v    = 1'b1;
                    fin_kind = sst_pkg::KIND_INVALID;
                end
                default:
                begin
                    fin_v = 1'b0;
                end
            endcase
            mode_next = sst_pkg::MODE_IDLE;
            len_next  = '0;
        end
        else
        begin
            unique case (mode_reg)
                sst_pkg::MODE_NUM:
                begin
                    if (head_item.cls.is_digit || head_item.cls.is_alpha)
                    begin
                        len_next = len_bump;
                        if (((ch == sst_pkg::CH_LOWER_E) || (ch == sst_pkg::CH_UPPER_E)) &&
                            (exp_reg != 2'd3))
                        begin
                            exp_next = exp_reg + 1'b1;
                        end
                    end
                    else if (head_item.cls.is_punct &&
                             (len_reg == sst_pkg::LEN_BITS'(1)) && dot_reg)
                    begin
                        // A lone leading dot followed by punctuation.
                        len_next  = len_bump;
                        fin_v     = 1'b1;
                        fin_kind  = sst_pkg::KIND_INVALID;
                        fin_len   = len_bump;
                        mode_next = sst_pkg::MODE_IDLE;
                    end
                    else if (ch == sst_pkg::CH_DOT)
                    begin
                        len_next = len_bump;
                        if (!dot_reg && (exp_reg == 2'd0))
                        begin
                            dot_next = 1'b1;
                        end
                        else
                        begin
                            // A second dot, or a dot after an exponent.
                            fin_v     = 1'b1;
                            fin_kind  = sst_pkg::KIND_INVALID;
                            fin_len   = len_bump;
                            mode_next = sst_pkg::MODE_IDLE;
                        end
                    end
                    else if (((ch == sst_pkg::CH_PLUS) || (ch == sst_pkg::CH_MINUS)) &&
                             (exp_reg == 2'd1) && prev_e_reg)
                    begin
                        len_next = len_bump;
                    end
                    else
                    begin
                        fin_v    = 1'b1;
                        fin_kind = sst_pkg::KIND_NUMBER;
                        scan     = 1'b1;
                    end
                end
                sst_pkg::MODE_STR:
                begin
                    if (ch == sst_pkg::CH_QUOTE)
                    begin
                        len_next  = len_bump;
                        fin_v     = 1'b1;
                        fin_kind  = sst_pkg::KIND_STRING;
                        fin_len   = len_bump;
                        mode_next = sst_pkg::MODE_IDLE;
                    end
                    else if (ch == sst_pkg::CH_NL)
                    begin
                        fin_v    = 1'b1;
                        fin_kind = sst_pkg::KIND_INVALID;
                        scan     = 1'b1;
                    end
                    else
                    begin
                        len_next = len_bump;
                    end
                end
                sst_pkg::MODE_SLASH:
                begin
                    if (ch == sst_pkg::CH_SLASH)
                    begin
                        len_next  = len_bump;
                        mode_next = sst_pkg::MODE_LINE;
                    end
                    else if (ch == sst_pkg::CH_STAR)
                    begin
                        len_next    = len_bump;
                        mode_next   = sst_pkg::MODE_BLOCK;
                        enter_block = 1'b1;
                    end
                    else
                    begin
                        fin_v    = 1'b1;
                        fin_kind = sst_pkg::KIND_OPER;
                        scan     = 1'b1;
                    end
                end
                sst_pkg::MODE_LINE:
                begin
                    len_next = len_bump;
                    if (ch == sst_pkg::CH_NL)
                    begin
                        fin_v     = 1'b1;
                        fin_kind  = sst_pkg::KIND_LINEC;
                        fin_len   = len_bump;
                        mode_next = sst_pkg::MODE_IDLE;
                    end
                end
                sst_pkg::MODE_BLOCK:
                begin
                    len_next = len_bump;
                    if ((ch == sst_pkg::CH_SLASH) && prev_star_reg)
                    begin
                        fin_v     = 1'b1;
                        fin_kind  = sst_pkg::KIND_BLOCKC;
                        fin_len   = len_bump;
                        mode_next = sst_pkg::MODE_IDLE;
                    end
                end
                sst_pkg::MODE_IDENT:
                begin
                    if (head_item.cls.is_digit || head_item.cls.is_alpha ||
                        (ch == sst_pkg::CH_UNDER))
                    begin
                        len_next = len_bump;
                    end
                    else
                    begin
                        fin_v    = 1'b1;
                        fin_kind = sst_pkg::KIND_IDENT;
                        scan     = 1'b1;
                    end
                end
                default:
                begin
                    scan = 1'b1;
                end
            endcase

            // Start-of-token scan of the byte, used between tokens and after an end.
            if (scan)
            begin
                mode_next = sst_pkg::MODE_IDLE;
                if (head_item.cls.is_blank)
                begin
                    idl_v = 1'b0;
                end
                else if (ch == sst_pkg::CH_NL)
                begin
                    idl_v    = 1'b1;
                    idl_kind = sst_pkg::KIND_NEWLINE;
                end
                else if (ch == sst_pkg::CH_QUOTE)
                begin
                    mode_next  = sst_pkg::MODE_STR;
                    start_next = head_item.pos;
                    len_next   = sst_pkg::LEN_BITS'(1);
                end
                else if ((ch == sst_pkg::CH_PLUS) || (ch == sst_pkg::CH_MINUS) ||
                         (ch == sst_pkg::CH_DOT) || head_item.cls.is_digit)
                begin
                    mode_next  = sst_pkg::MODE_NUM;
                    start_next = head_item.pos;
                    len_next   = sst_pkg::LEN_BITS'(1);
                    dot_next   = (ch == sst_pkg::CH_DOT);
                    exp_next   = 2'd0;
                end
                else if (ch == sst_pkg::CH_SLASH)
                begin
                    mode_next  = sst_pkg::MODE_SLASH;
                    start_next = head_item.pos;
                    len_next   = sst_pkg::LEN_BITS'(1);
                end
                else if ((ch == sst_pkg::CH_UNDER) || head_item.cls.is_alpha)
                begin
                    mode_next  = sst_pkg::MODE_IDENT;
                    start_next = head_item.pos;
                    len_next   = sst_pkg::LEN_BITS'(1);
                end
                else if (head_item.cls.is_punct)
                begin
                    idl_v    = 1'b1;
                    idl_kind = sst_pkg::KIND_OPER;
                end
                else
                begin
                    idl_v    = 1'b1;
                    idl_kind = sst_pkg::KIND_INVALID;
                end
            end

            // Remember whether this byte may start an exponent sign or close a comment.
            prev_e_next    = !enter_block &&
                             ((ch == sst_pkg::CH_LOWER_E) || (ch == sst_pkg::CH_UPPER_E));
            prev_star_next = !enter_block && (ch == sst_pkg::CH_STAR);
        end
    end

    // Assemble the one or two results of the item.
    always_comb
    begin
        fin_tok.kind   = fin_kind;
        fin_tok.start  = start_reg;
        fin_tok.length = fin_len;
        fin_tok.last   = !idl_v;
        idl_tok.kind   = idl_kind;
        idl_tok.start  = head_item.pos;
        idl_tok.length = sst_pkg::LEN_BITS'(1);
        idl_tok.last   = 1'b1;
        res_a          = fin_v ? fin_tok : idl_tok;
        res_n          = {1'b0, fin_v} + {1'b0, idl_v};
    end

    // Result buffer: load a fresh item's results or shift after a transfer.
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_reg;
        if (take)
        begin
            slot_next[0] = res_a;
            slot_next[1] = idl_tok;
            cnt_next     = res_n;
        end
        else if (out_pop)
        begin
            slot_next[0] = slot_reg[1];
            cnt_next     = cnt_reg - 1'b1;
        end
    end

    // Control and scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sst_pkg::MODE_IDLE;
            dot_reg       <= 1'b0;
            exp_reg       <= 2'd0;
            prev_e_reg    <= 1'b0;
            prev_star_reg <= 1'b0;
            start_reg     <= '0;
            len_reg       <= '0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (take)
            begin
                mode_reg      <= mode_next;
                dot_reg       <= dot_next;
                exp_reg       <= exp_next;
                prev_e_reg    <= prev_e_next;
                prev_star_reg <= prev_star_next;
                start_reg     <= start_next;
                len_reg       <= len_next;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // The buffer never holds more than two results.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    // The end marker always leaves the scanner idle with a cleared length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && head_item.cmd) |=> ((mode_reg == sst_pkg::MODE_IDLE) && (len_reg == '0)))
        else $error("scanner not idle after end of source");

    // An item with two results fills the buffer, and only the second is marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (res_n == 2'd2)) |=> ((cnt_reg == 2'd2) && !slot_reg[0].last &&
                                        slot_reg[1].last))
        else $error("two-result item stored wrongly");

endmodule

FILE: sv/shader_source_tokenizer.sv
`timescale 1ns / 1ps

// Streaming tokenizer for C-style shader source. Each transfer on the source channel
// carries one byte (cmd 0) or an end-of-source marker (cmd 1) that flushes any pending
// token; each transfer on the token channel carries a kind, start offset, length and a
// flag marking the last token caused by one source item. A front end classifies each
// byte and stamps it with its stream offset, a four-entry queue decouples it from the
// scanner, and the scanner keeps a two-entry result buffer. The block takes one source
// item per cycle while the token channel does not stall; an item that yields two tokens
// (an ended token plus the byte's own one-byte token) holds the scanner while the second
// token drains from the result buffer. A source item passes through the queue entry
// registers and then the result buffer before its first token shows on the token channel.

module shader_source_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic        cmd,
    input  logic [7:0]  source_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [2:0]  token_kind,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    logic            push_valid;
    sst_pkg::item_t  push_item;
    logic            queue_full;
    logic            head_valid;
    sst_pkg::item_t  head_item;
    logic            pop;
    sst_pkg::tok_t   tok_out;

    // Byte classification and offset stamping.
    sst_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .cmd         (cmd),
        .source_byte (source_byte),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .queue_full  (queue_full)
    );

    // Queue between the classifier and the scanner.
    sst_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // Token scanner and result buffer.
    sst_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_out    (tok_out)
    );

    // Result fields on the token channel.
    assign token_kind   = tok_out.kind;
    assign token_start  = 32'(tok_out.start);
    assign token_length = 16'(tok_out.length);
    assign last_of_run  = tok_out.last;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sst_pkg::*;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int CALM_ITEMS    = 200;
    localparam int STUCK_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 10;

    // One row of the opening script. When typed is set, the token given here is the
    // single result the row must produce.
    typedef struct packed {
        logic        cmd_bit;
        logic [7:0]  ch;
        logic        typed;
        kind_t       kind;
        logic [31:0] start;
        logic [15:0] length;
    } script_row_t;

    localparam script_row_t OPENING_SCRIPT [26] = '{
        '{1'b0, 8'h00,    1'b1, KIND_INVALID, 32'd0,  16'd1},
        '{1'b0, 8'hFF,    1'b1, KIND_INVALID, 32'd1,  16'd1},
        '{1'b0, CH_NL,    1'b1, KIND_NEWLINE, 32'd2,  16'd1},
        '{1'b0, "@",      1'b1, KIND_OPER,    32'd3,  16'd1},
        '{1'b0, CH_DOT,   1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, ";",      1'b1, KIND_INVALID, 32'd4,  16'd2},
        '{1'b0, "1",      1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_DOT,   1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_DOT,   1'b1, KIND_INVALID, 32'd6,  16'd3},
        '{1'b0, "2",      1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_UPPER_E, 1'b0, KIND_INVALID, 32'd0, 16'd0},
        '{1'b0, CH_MINUS, 1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, "7",      1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_TAB,   1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_QUOTE, 1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, "a",      1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_NL,    1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_SLASH, 1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_STAR,  1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_STAR,  1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_SLASH, 1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, CH_UNDER, 1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, "z",      1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b1, 8'hFF,    1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b1, 8'h00,    1'b0, KIND_INVALID, 32'd0,  16'd0},
        '{1'b0, 8'h7F,    1'b1, KIND_INVALID, 32'd23, 16'd1}
    };

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic        cmd;
    logic [7:0]  source_byte;
    logic        tok_valid;
    logic        tok_stall;
    logic [2:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    // Lexer state kept by the testbench.
    mode_t       scan_mode;
    logic [1:0]  dot_seen;
    logic [1:0]  exp_seen;
    logic [7:0]  prev_byte;
    logic [31:0] tok_begin;
    logic [15:0] tok_len;
    logic [31:0] byte_offset;

    tok_t        step_tokens[$];
    tok_t        expected_tokens[$];

    int          sent_items  = 0;
    int          seen_tokens = 0;
    int          failures    = 0;
    int          stuck_cycles;
    bit          idle_enable;

    shader_source_tokenizer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .cmd          (cmd),
        .source_byte  (source_byte),
        .tok_valid    (tok_valid),
        .tok_stall    (tok_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = ~clk;
    end

    // Character classes.
    function automatic bit ch_is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit ch_is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit ch_is_punct(logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    task automatic emit_token(kind_t k, logic [31:0] s, logic [15:0] l);
        tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic open_token(mode_t m, logic [31:0] pos);
        scan_mode = m;
        tok_begin = pos;
        tok_len   = 16'd1;
    endtask

    task automatic close_token(kind_t k);
        emit_token(k, tok_begin, tok_len);
        scan_mode = MODE_IDLE;
    endtask

    // The length counter sticks at its maximum.
    task automatic grow_token();
        if (tok_len != 16'hFFFF)
        begin
            tok_len = tok_len + 16'd1;
        end
    endtask

    // A byte seen between tokens either starts a token or forms a one-byte token.
    task automatic scan_fresh(logic [7:0] b, logic [31:0] pos);
        scan_mode = MODE_IDLE;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR)
        begin
        end
        else if (b == CH_NL)
        begin
            emit_token(KIND_NEWLINE, pos, 16'd1);
        end
        else if (b == CH_QUOTE)
        begin
            open_token(MODE_STR, pos);
        end
        else if (b == CH_PLUS || b == CH_MINUS || b == CH_DOT || ch_is_digit(b))
        begin
            open_token(MODE_NUM, pos);
            dot_seen = (b == CH_DOT) ? 2'd1 : 2'd0;
            exp_seen = 2'd0;
        end
        else if (b == CH_SLASH)
        begin
            open_token(MODE_SLASH, pos);
        end
        else if (b == CH_UNDER || ch_is_alpha(b))
        begin
            open_token(MODE_IDENT, pos);
        end
        else if (ch_is_punct(b))
        begin
            emit_token(KIND_OPER, pos, 16'd1);
        end
        else
        begin
            emit_token(KIND_INVALID, pos, 16'd1);
        end
    endtask

    // Works out the tokens that one source item causes, leaving them in step_tokens.
    task automatic lex_item(logic c, logic [7:0] b);
        logic [31:0] pos;
        logic [7:0]  next_prev;
        pos       = byte_offset;
        next_prev = b;
        step_tokens.delete();
        if (c)
        begin
            // End of source flushes whatever is pending.
            case (scan_mode)
                MODE_NUM:   close_token(KIND_NUMBER);
                MODE_IDENT: close_token(KIND_IDENT);
                MODE_SLASH: close_token(KIND_OPER);
                MODE_STR, MODE_LINE, MODE_BLOCK: close_token(KIND_INVALID);
                default: ;
            endcase
            scan_mode = MODE_IDLE;
            tok_len   = 16'd0;
        end
        else
        begin
            case (scan_mode)
                MODE_NUM:
                begin
                    if (ch_is_digit(b) || ch_is_alpha(b))
                    begin
                        grow_token();
                        if ((b == CH_LOWER_E || b == CH_UPPER_E) && exp_seen < 2'd3)
                        begin
                            exp_seen = exp_seen + 2'd1;
                        end
                    end
                    else if (ch_is_punct(b) && tok_len == 16'd1 && dot_seen != 2'd0)
                    begin
                        // A lone leading dot swallows the punctuation after it.
                        grow_token();
                        close_token(KIND_INVALID);
                    end
                    else if (b == CH_DOT)
                    begin
                        grow_token();
                        if (dot_seen == 2'd0 && exp_seen == 2'd0)
                        begin
                            dot_seen = 2'd1;
                        end
                        else
                        begin
                            close_token(KIND_INVALID);
                        end
                    end
                    else if ((b == CH_PLUS || b == CH_MINUS) && exp_seen == 2'd1 &&
                             (prev_byte == CH_LOWER_E || prev_byte == CH_UPPER_E))
                    begin
                        grow_token();
                    end
                    else
                    begin
                        close_token(KIND_NUMBER);
                        scan_fresh(b, pos);
                    end
                end
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        grow_token();
                        close_token(KIND_STRING);
                    end
                    else if (b == CH_NL)
                    begin
                        close_token(KIND_INVALID);
                        scan_fresh(b, pos);
                    end
                    else
                    begin
                        grow_token();
                    end
                end
                MODE_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        grow_token();
                        scan_mode = MODE_LINE;
                    end
                    else if (b == CH_STAR)
                    begin
                        // The opening star must not pair with a following slash.
                        grow_token();
                        scan_mode = MODE_BLOCK;
                        next_prev = 8'd0;
                    end
                    else
                    begin
                        close_token(KIND_OPER);
                        scan_fresh(b, pos);
                    end
                end
                MODE_LINE:
                begin
                    grow_token();
                    if (b == CH_NL)
                    begin
                        close_token(KIND_LINEC);
                    end
                end
                MODE_BLOCK:
                begin
                    grow_token();
                    if (b == CH_SLASH && prev_byte == CH_STAR)
                    begin
                        close_token(KIND_BLOCKC);
                    end
                end
                MODE_IDENT:
                begin
                    if (ch_is_digit(b) || ch_is_alpha(b) || b == CH_UNDER)
                    begin
                        grow_token();
                    end
                    else
                    begin
                        close_token(KIND_IDENT);
                        scan_fresh(b, pos);
                    end
                end
                default: scan_fresh(b, pos);
            endcase
            prev_byte   = next_prev;
            byte_offset = pos + 32'd1;
        end
        if (step_tokens.size() > 0)
        begin
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        end
    endtask

    // Presents one source item, waits for its transfer and records the tokens it causes.
    task automatic send_item(input logic c, input logic [7:0] b, input logic typed,
                             input tok_t typed_tok);
        if (idle_enable && $urandom_range(0, 9) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        src_valid   <= 1'b1;
        cmd         <= c;
        source_byte <= b;
        // Stall seen at the falling edge holds through the next rising edge.
        do @(negedge clk); while (src_stall);
        @(posedge clk);
        lex_item(c, b);
        if (typed)
        begin
            expected_tokens.push_back(typed_tok);
        end
        else
        begin
            foreach (step_tokens[i])
            begin
                expected_tokens.push_back(step_tokens[i]);
            end
        end
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b, 1'b0, '0);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alpha();
        int v;
        v = $urandom_range(0, 51);
        return (v < 26) ? 8'("a" + v) : 8'("A" + v - 26);
    endfunction

    function automatic logic [7:0] rand_punct();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 126)); while (!ch_is_punct(b));
        return b;
    endfunction

    // Sends one short piece of source: mostly well-formed tokens with random content,
    // the rest broken pieces, stray bytes and end-of-source markers.
    task automatic send_fragment();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(CH_PLUS);
                1: send_byte(CH_MINUS);
                2: send_byte(CH_DOT);
                default: ;
            endcase
            repeat ($urandom_range(1, 4)) send_byte(rand_digit());
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte(CH_DOT);
                repeat ($urandom_range(0, 3)) send_byte(rand_digit());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
                if ($urandom_range(0, 1))
                begin
                    send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                end
                repeat ($urandom_range(1, 3)) send_byte(rand_digit());
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_byte($urandom_range(0, 1) ? CH_DOT : CH_LOWER_E);
            end
        end
        else if (pick < 35)
        begin
            send_byte($urandom_range(0, 4) == 0 ? CH_UNDER : rand_alpha());
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 3))
                    0: send_byte(rand_digit());
                    1: send_byte(CH_UNDER);
                    default: send_byte(rand_alpha());
                endcase
            end
        end
        else if (pick < 45)
        begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                b = 8'($urandom_range(32, 126));
                if (b == CH_QUOTE)
                begin
                    b = "q";
                end
                send_byte($urandom_range(0, 9) == 0 ? CH_NL : b);
            end
            if ($urandom_range(0, 7) != 0)
            begin
                send_byte(CH_QUOTE);
            end
        end
        else if (pick < 53)
        begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            repeat ($urandom_range(0, 8))
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b == CH_NL ? CH_SPACE : b);
            end
            if ($urandom_range(0, 7) != 0)
            begin
                send_byte(CH_NL);
            end
        end
        else if (pick < 61)
        begin
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            repeat ($urandom_range(0, 8))
            begin
                case ($urandom_range(0, 3))
                    0: send_byte(CH_STAR);
                    1: send_byte(CH_SLASH);
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
        end
        else if (pick < 71)
        begin
            send_byte($urandom_range(0, 3) == 0 ? CH_SLASH : rand_punct());
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_TAB);
                2: send_byte(CH_CR);
                default: send_byte(CH_NL);
            endcase
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
    endtask

    // Random stall bursts on the token channel.
    initial
    begin : token_backpressure
        tok_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                tok_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                tok_stall <= 1'b0;
            end
        end
    end

    // Each token transfer is checked against the oldest expected token.
    initial
    begin : token_checker
        tok_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && tok_valid === 1'b1 && !tok_stall)
            begin
                seen_tokens++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           token_kind, token_start, token_length);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
                        failures++;
                    end
                    if (token_start !== want.start)
                    begin
                        $error("token_start: expected %0d, got %0d", want.start, token_start);
                        failures++;
                    end
                    if (token_length !== want.length)
                    begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, token_length);
                        failures++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                        failures++;
                    end
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial
    begin : watchdog
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
        end
        $error("no transfer for %0d cycles, %0d tokens still expected",
               STUCK_LIMIT, expected_tokens.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        tok_t       row_tok;
        int         random_base;

        rst_n       = 1'b0;
        src_valid   = 1'b0;
        cmd         = 1'b0;
        source_byte = 8'd0;
        idle_enable = 1'b1;
        scan_mode   = MODE_IDLE;
        dot_seen    = 2'd0;
        exp_seen    = 2'd0;
        prev_byte   = 8'd0;
        tok_begin   = 32'd0;
        tok_len     = 16'd0;
        byte_offset = 32'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening script: byte extremes, each special case and both commands.
        foreach (OPENING_SCRIPT[i])
        begin
            row_tok.kind   = OPENING_SCRIPT[i].kind;
            row_tok.start  = OPENING_SCRIPT[i].start;
            row_tok.length = OPENING_SCRIPT[i].length;
            row_tok.last   = 1'b1;
            send_item(OPENING_SCRIPT[i].cmd_bit, OPENING_SCRIPT[i].ch,
                      OPENING_SCRIPT[i].typed, row_tok);
        end

        // Random source; every fourth stretch and the tail run without idling.
        random_base = sent_items;
        while (sent_items - random_base < RANDOM_ITEMS)
        begin
            idle_enable = (sent_items - random_base < RANDOM_ITEMS - CALM_ITEMS) &&
                          (((sent_items - random_base) / 100) % 4 != 3);
            send_fragment();
        end
        send_item(1'b1, 8'h00, 1'b0, '0);
        src_valid <= 1'b0;

        while (expected_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d source items and checked %0d tokens of every kind,", sent_items,
                 seen_tokens);
        $display("including broken numbers, open strings and end-of-source flushes.");
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
